@@ src/blpm_pkg.sv @@
`default_nettype none
package blpm_pkg;

    localparam int NODE_COUNT_DEF    = 4096;
    localparam int ROUTE_ID_BITS_DEF = 16;

    localparam int ADDR_BITS = 32;
    localparam int TOP_BIT   = 31;
    localparam int ROUTE_W   = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage
`default_nettype wire

@@ src/blpm_stream_if.sv @@
`default_nettype none
interface blpm_req_if;
    import blpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [ADDR_BITS-1:0] ip_addr;
    logic [ADDR_BITS-1:0] prefix_mask;
    logic [ROUTE_W-1:0]   route_id;

    modport source (output valid, output cmd, output ip_addr, output prefix_mask,
                    output route_id, input ready);
    modport sink   (input valid, input cmd, input ip_addr, input prefix_mask,
                    input route_id, output ready);
endinterface

interface blpm_rsp_if;
    import blpm_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [ROUTE_W-1:0] match_route;
    logic               status;

    modport source (output valid, output hit, output match_route, output status,
                    input ready);
    modport sink   (input valid, input hit, input match_route, input status,
                    output ready);
endinterface
`default_nettype wire

@@ src/binary_trie_longest_prefix_match_top.sv @@
// Longest-prefix-match engine for IPv4 on a one-bit binary trie.
// i_req carries one item: cmd (0 insert, 1 lookup), ip_addr, prefix_mask and
// route_id. o_rsp returns exactly one item per request: hit, match_route and
// status (1 when an insert ran out of pool nodes).
// Steps: the request is taken in the idle state, then the walk handles one
// trie level per step plus a closing step, which loads the result into the
// output register. An insert walks L levels for prefix length L unless the
// pool runs out; a lookup descends until a child is missing or all 32 bits
// are used. The walk is paced by the node RAM: one child fetch per level,
// whose read data feeds the next level's fetch address directly.
// One item is in flight at a time; ready rises again as soon as the walk ends,
// even while the previous result still waits on o_rsp.
// Reset clears the root node (kept in flops) and sets the allocation counter
// to 1. Pool nodes are written when allocated, so no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and a
// finished walk waits at its last step until that register frees.
`default_nettype none
module binary_trie_longest_prefix_match_top #(
    parameter int NODE_COUNT    = blpm_pkg::NODE_COUNT_DEF,
    parameter int ROUTE_ID_BITS = blpm_pkg::ROUTE_ID_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    blpm_req_if.sink   i_req,
    blpm_rsp_if.source o_rsp
);
    import blpm_pkg::*;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int NODE_W = 2 * IDX_W + 1 + ROUTE_ID_BITS;

    t_ram_ctl          ram_ctl;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [NODE_W-1:0] ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [NODE_W-1:0] ram_rd_data;

    blpm_walk #(
        .NODE_COUNT    (NODE_COUNT),
        .ROUTE_ID_BITS (ROUTE_ID_BITS),
        .IDX_W         (IDX_W),
        .NODE_W        (NODE_W)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_ram_ctl     (ram_ctl),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    blpm_node_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (NODE_W)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule
`default_nettype wire

@@ src/blpm_node_ram.sv @@
`default_nettype none
module blpm_node_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 41
) (
    input  wire logic              i_clk,
    input  wire blpm_pkg::t_ram_ctl i_ctl,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);
    import blpm_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/blpm_walk.sv @@
`default_nettype none
module blpm_walk #(
    parameter int NODE_COUNT    = blpm_pkg::NODE_COUNT_DEF,
    parameter int ROUTE_ID_BITS = blpm_pkg::ROUTE_ID_BITS_DEF,
    parameter int IDX_W         = $clog2(NODE_COUNT),
    parameter int NODE_W        = 2 * IDX_W + 1 + ROUTE_ID_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    blpm_req_if.sink                 i_req,
    blpm_rsp_if.source               o_rsp,
    output blpm_pkg::t_ram_ctl       o_ram_ctl,
    output logic [IDX_W-1:0]         o_ram_wr_addr,
    output logic [NODE_W-1:0]        o_ram_wr_data,
    output logic [IDX_W-1:0]         o_ram_rd_addr,
    input  wire logic [NODE_W-1:0]   i_ram_rd_data
);
    import blpm_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam int RID_W = ROUTE_ID_BITS;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [ADDR_BITS-1:0] r_mask, n_mask;
    logic [RID_W-1:0]    r_rid, n_rid;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [NODE_W-1:0]   r_root, n_root;
    logic                r_use_rd, n_use_rd;
    logic                r_found, n_found;
    logic [RID_W-1:0]    r_best, n_best;
    logic [CNT_W-1:0]    r_free, n_free;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [ROUTE_W-1:0]  r_out_route, n_out_route;
    logic                r_out_status, n_out_status;

    logic [NODE_W-1:0]   cur_node;
    logic [RID_W-1:0]    node_route;
    logic                node_has;
    logic [IDX_W-1:0]    node_child0;
    logic [IDX_W-1:0]    node_child1;
    logic [IDX_W-1:0]    nxt;
    logic                addr_bit;
    logic                out_free;
    logic                pool_full;
    logic                node_wr;
    logic [NODE_W-1:0]   wr_node;
    logic [RID_W+ROUTE_W-1:0] rid_ext;
    logic [RID_W+ROUTE_W-1:0] best_ext;
    logic [RID_W-1:0]    root_route;
    logic                root_has;

    // current node comes from the RAM right after a child fetch
    assign cur_node    = r_use_rd ? i_ram_rd_data : r_node;
    assign node_route  = cur_node[RID_W-1:0];
    assign node_has    = cur_node[RID_W];
    assign node_child0 = cur_node[RID_W+IDX_W:RID_W+1];
    assign node_child1 = cur_node[NODE_W-1:RID_W+IDX_W+1];
    assign addr_bit    = r_addr[TOP_BIT];
    assign nxt         = addr_bit ? node_child1 : node_child0;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign pool_full   = r_free >= CNT_W'(NODE_COUNT);
    assign rid_ext     = {RID_W'(0), i_req.route_id};
    assign root_route  = r_root[RID_W-1:0];
    assign root_has    = r_root[RID_W];

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.match_route = r_out_route;
    assign o_rsp.status      = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_root      <= '0;
            r_free      <= CNT_W'(1);
            r_use_rd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root      <= n_root;
            r_free      <= n_free;
            r_use_rd    <= n_use_rd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_mask       <= n_mask;
        r_rid        <= n_rid;
        r_cur        <= n_cur;
        r_node       <= n_node;
        r_found      <= n_found;
        r_best       <= n_best;
        r_out_hit    <= n_out_hit;
        r_out_route  <= n_out_route;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_mask       = r_mask;
        n_rid        = r_rid;
        n_cur        = r_cur;
        n_node       = r_node;
        n_root       = r_root;
        n_use_rd     = 1'b0;
        n_found      = r_found;
        n_best       = r_best;
        n_free       = r_free;
        n_out_valid  = r_out_valid;
        n_out_hit    = r_out_hit;
        n_out_route  = r_out_route;
        n_out_status = r_out_status;
        node_wr      = 1'b0;
        wr_node      = cur_node;
        o_ram_ctl    = '0;
        o_ram_rd_addr = nxt;
        best_ext     = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state  = ST_WALK;
                    n_cmd    = t_cmd'(i_req.cmd);
                    n_addr   = i_req.ip_addr;
                    n_mask   = (t_cmd'(i_req.cmd) == CMD_LOOKUP) ? '1 : i_req.prefix_mask;
                    n_rid    = rid_ext[RID_W-1:0];
                    n_cur    = '0;
                    n_node   = r_root;
                    n_found  = root_has;
                    n_best   = root_route;
                end
            end
            ST_WALK: begin
                // pick up the route of a freshly fetched node
                if (r_cmd == CMD_LOOKUP && r_use_rd && node_has) begin
                    n_found = 1'b1;
                    n_best  = node_route;
                end
                n_node = cur_node;

                if (!r_mask[TOP_BIT] || (nxt == '0 && (r_cmd == CMD_LOOKUP || pool_full))) begin
                    // end of walk; hold until the output register is free
                    if (out_free) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        if (r_cmd == CMD_LOOKUP) begin
                            best_ext     = {ROUTE_W'(0), n_best};
                            n_out_hit    = n_found;
                            n_out_route  = n_found ? best_ext[ROUTE_W-1:0] : '0;
                            n_out_status = 1'b0;
                        end else begin
                            node_wr      = 1'b1;
                            n_out_hit    = 1'b0;
                            n_out_route  = '0;
                            n_out_status = r_mask[TOP_BIT];
                            if (!r_mask[TOP_BIT]) begin
                                wr_node = {node_child1, node_child0, 1'b1, r_rid};
                            end
                        end
                    end
                end else if (nxt != '0) begin
                    o_ram_ctl.rd_en = 1'b1;
                    n_use_rd = 1'b1;
                    n_cur    = nxt;
                    n_addr   = {r_addr[TOP_BIT-1:0], 1'b0};
                    n_mask   = {r_mask[TOP_BIT-1:0], 1'b0};
                end else begin
                    // allocate a child, write back the parent with its new link
                    node_wr = 1'b1;
                    if (addr_bit) begin
                        wr_node = {r_free[IDX_W-1:0], node_child0, node_has, node_route};
                    end else begin
                        wr_node = {node_child1, r_free[IDX_W-1:0], node_has, node_route};
                    end
                    n_node = '0;
                    n_cur  = r_free[IDX_W-1:0];
                    n_free = r_free + CNT_W'(1);
                    n_addr = {r_addr[TOP_BIT-1:0], 1'b0};
                    n_mask = {r_mask[TOP_BIT-1:0], 1'b0};
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (node_wr) begin
            if (r_cur == '0) begin
                n_root = wr_node;
            end else begin
                o_ram_ctl.wr_en = 1'b1;
            end
        end
    end

    assign o_ram_wr_addr = r_cur;
    assign o_ram_wr_data = wr_node;

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_ctl.wr_en && o_ram_ctl.rd_en))
        else $error("node RAM read and write in one cycle");

    a_no_root_in_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_ctl.wr_en |-> o_ram_wr_addr != '0)
        else $error("root node written to RAM");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free != '0 && r_free <= CNT_W'(NODE_COUNT))
        else $error("free node counter out of range");

    a_fetch_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_ctl.rd_en |=> r_state == ST_WALK && r_use_rd)
        else $error("child fetch outside a walk");

    a_hit_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_status))
        else $error("result carries both hit and full status");

endmodule
`default_nettype wire

@@ test/binary_trie_longest_prefix_match_top_tb.sv @@
`default_nettype none
module binary_trie_longest_prefix_match_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blpm_pkg::*;

    localparam int NODES           = NODE_COUNT_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] mask;
        logic [ROUTE_W-1:0]   rid;
    } t_lpm_req;

    typedef struct packed {
        logic               hit;
        logic [ROUTE_W-1:0] route;
        logic               status;
    } t_lpm_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    blpm_req_if req_if ();
    blpm_rsp_if rsp_if ();

    binary_trie_longest_prefix_match_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the node pool
    int unsigned        kid0 [NODES];
    int unsigned        kid1 [NODES];
    bit                 has_rt [NODES];
    logic [ROUTE_W-1:0] rt [NODES];
    int unsigned        next_free;

    t_lpm_req pending_reqs [$];
    t_lpm_rsp routes_due [$];
    logic [ADDR_BITS-1:0] route_bases [16];

    int errors;
    int n_ins, n_full, n_look, n_hit;
    int send_idle_pct, recv_stall_pct;
    int hold_requests, holds_served, rx_hold_left;
    int quiet_cycles;
    logic req_taken;
    t_lpm_req drv_item, mon_item;
    t_lpm_rsp want;

    function automatic int unsigned lead_ones(logic [ADDR_BITS-1:0] m);
        int unsigned n;
        bit run;
        n = 0;
        run = 1'b1;
        for (int i = TOP_BIT; i >= 0; i--) begin
            if (run && m[i]) n++;
            else run = 1'b0;
        end
        return n;
    endfunction

    function automatic t_lpm_rsp trie_step(t_lpm_req it);
        t_lpm_rsp r;
        int unsigned cur, nxt, len, lvl;
        bit ok, b, walking;
        r = '0;
        cur = 0;
        if (it.cmd == CMD_INSERT) begin
            len = lead_ones(it.mask);
            ok = 1'b1;
            for (lvl = 0; lvl < len && ok; lvl++) begin
                b = it.addr[TOP_BIT - lvl];
                nxt = b ? kid1[cur] : kid0[cur];
                if (nxt == 0) begin
                    if (next_free >= NODES) begin
                        ok = 1'b0;
                    end else begin
                        nxt = next_free;
                        next_free++;
                        kid0[nxt] = 0;
                        kid1[nxt] = 0;
                        has_rt[nxt] = 1'b0;
                        rt[nxt] = '0;
                        if (b) kid1[cur] = nxt;
                        else kid0[cur] = nxt;
                    end
                end
                if (ok) cur = nxt;
            end
            // a refused insert leaves its new nodes in place but stores no route
            if (ok) begin
                has_rt[cur] = 1'b1;
                rt[cur] = it.rid;
            end
            r.status = !ok;
        end else begin
            r.hit = has_rt[0];
            r.route = rt[0];
            walking = 1'b1;
            for (lvl = 0; lvl < ADDR_BITS && walking; lvl++) begin
                b = it.addr[TOP_BIT - lvl];
                nxt = b ? kid1[cur] : kid0[cur];
                if (nxt == 0) begin
                    walking = 1'b0;
                end else begin
                    cur = nxt;
                    if (has_rt[cur]) begin
                        r.hit = 1'b1;
                        r.route = rt[cur];
                    end
                end
            end
            if (!r.hit) r.route = '0;
        end
        return r;
    endfunction

    task automatic add_req(t_cmd cmd, logic [31:0] addr, logic [31:0] mask,
                           logic [15:0] rid);
        t_lpm_req it;
        it.cmd = cmd;
        it.addr = addr;
        it.mask = mask;
        it.rid = rid;
        pending_reqs.push_back(it);
    endtask

    task automatic gen_traffic(int n, int ins_pct, bit exhaust);
        t_lpm_req it;
        int unsigned len, k;
        for (int i = 0; i < n; i++) begin
            it.rid = 16'($urandom_range(0, 65535));
            it.cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_LOOKUP;
            // mostly stay near a few shared prefixes so the walks go deep
            k = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 10) : $urandom_range(11, 32);
            it.addr = route_bases[$urandom_range(0, 15)] ^ ($urandom & (32'hFFFFFFFF >> (32 - k)));
            if (exhaust && it.cmd == CMD_INSERT && $urandom_range(0, 99) < 70) begin
                it.addr = $urandom;
                it.mask = '1;
            end else begin
                len = $urandom_range(0, 1) ? $urandom_range(0, 32) : $urandom_range(12, 24);
                it.mask = ~(32'hFFFFFFFF >> len);
                case ($urandom_range(0, 9))
                    0: it.mask = $urandom;
                    1: if (len < 31) it.mask |= $urandom & (32'hFFFFFFFF >> (len + 1));
                    default: ;
                endcase
            end
            pending_reqs.push_back(it);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || routes_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item = pending_reqs.pop_front();
                req_if.valid       <= 1'b1;
                req_if.cmd         <= drv_item.cmd;
                req_if.ip_addr     <= drv_item.addr;
                req_if.prefix_mask <= drv_item.mask;
                req_if.route_id    <= drv_item.rid;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rx_hold_left = HOLD_OFF_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                mon_item.cmd  = t_cmd'(req_if.cmd);
                mon_item.addr = req_if.ip_addr;
                mon_item.mask = req_if.prefix_mask;
                mon_item.rid  = req_if.route_id;
                want = trie_step(mon_item);
                routes_due.push_back(want);
                if (mon_item.cmd == CMD_INSERT) begin
                    n_ins++;
                    if (want.status) n_full++;
                end else begin
                    n_look++;
                    if (want.hit) n_hit++;
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (routes_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with none pending: hit=%0d route=%h status=%0d",
                                 $realtime, rsp_if.hit, rsp_if.match_route, rsp_if.status);
                end else begin
                    want = routes_due.pop_front();
                    if (rsp_if.hit !== want.hit || rsp_if.match_route !== want.route ||
                        rsp_if.status !== want.status) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected hit=%0d route=%h status=%0d, %s",
                                     $realtime, want.hit, want.route, want.status,
                                     $sformatf("got hit=%0d route=%h status=%0d",
                                               rsp_if.hit, rsp_if.match_route,
                                               rsp_if.status));
                    end
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (pending_reqs.size() == 0 && !req_if.valid && routes_due.size() == 0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, routes_due.size());
                $display("binary_trie_longest_prefix_match_top_tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        errors = 0;
        n_ins = 0;
        n_full = 0;
        n_look = 0;
        n_hit = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        holds_served = 0;
        rx_hold_left = 0;
        quiet_cycles = 0;
        req_taken = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_INSERT;
        req_if.ip_addr = '0;
        req_if.prefix_mask = '0;
        req_if.route_id = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            kid0[i] = 0;
            kid1[i] = 0;
            has_rt[i] = 1'b0;
            rt[i] = '0;
        end
        next_free = 1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then the corner cases one by one
        add_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        add_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(CMD_INSERT, 32'h0A12_3456, 32'hFF00_0000, 16'h0101);
        add_req(CMD_LOOKUP, 32'h0AFF_FFFF, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'h0A00_0000, 32'hFF00_FF00, 16'h0202);
        add_req(CMD_LOOKUP, 32'h0A00_0001, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        add_req(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
        add_req(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(CMD_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 16'h8000);
        add_req(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'hDEAD_BEEF, 32'h0000_0000, 16'h1234);
        add_req(CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'h5555_5555, 32'h7FFF_FFFF, 16'h4321);
        add_req(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 16'h00FF);
        add_req(CMD_LOOKUP, 32'hC000_0000, 32'h0000_0000, 16'h0000);
        add_req(CMD_LOOKUP, 32'h0A00_0000, 32'h0000_0000, 16'h0000);
        add_req(CMD_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFF0, 16'h7E7E);
        add_req(CMD_LOOKUP, 32'hAAAA_AAAF, 32'h0000_0000, 16'h0000);
        drain();

        route_bases[0] = 32'h0A00_0000;
        route_bases[1] = 32'hFFFF_FFFF;
        route_bases[2] = 32'h0000_0000;
        for (int i = 3; i < 16; i++) route_bases[i] = $urandom;

        gen_traffic(340, 40, 1'b0);
        drain();

        send_idle_pct = 48;
        gen_traffic(340, 40, 1'b0);
        drain();

        // hold the receiver off while requests keep coming, so the input backs up
        send_idle_pct = 0;
        recv_stall_pct = 48;
        hold_requests++;
        gen_traffic(340, 40, 1'b0);
        drain();

        send_idle_pct = 12;
        recv_stall_pct = 12;
        gen_traffic(340, 40, 1'b0);
        drain();

        // deep random inserts to run the pool dry
        gen_traffic(350, 60, 1'b1);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d inserts (%0d refused with the pool full, %0d nodes in use)",
                 n_ins, n_full, next_free);
        $display("and %0d lookups (%0d matched); %0d mismatches", n_look, n_hit, errors);
        if (errors == 0) begin
            $display("binary_trie_longest_prefix_match_top_tb: done, clean");
        end else begin
            $display("binary_trie_longest_prefix_match_top_tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
src/blpm_pkg.sv
src/blpm_stream_if.sv
src/blpm_node_ram.sv
src/blpm_walk.sv
src/binary_trie_longest_prefix_match_top.sv
test/binary_trie_longest_prefix_match_top_tb.sv
